// ===== design/isod_pkg.sv =====
// Shared constants, codes and types of the ISODATA threshold binarizer.
`default_nettype none

package isod_pkg;

	// Frame size bound and the storage widths that follow from the default.
	localparam int unsigned MAX_FRAME_PIXELS_DEF = 1048576;
	localparam int unsigned BIN_W_DEF = $clog2(MAX_FRAME_PIXELS_DEF + 1);
	localparam int unsigned CNT_W_DEF = BIN_W_DEF + 8;
	localparam int unsigned SUM_W_DEF = CNT_W_DEF + 8;

	// Grey levels and histogram size.
	localparam int unsigned PIX_W = 8;
	localparam int unsigned NUM_BINS = 256;

	// Configuration reset values.
	localparam logic [PIX_W-1:0] START_THR_RESET = 8'd50;
	localparam logic [7:0] ITER_LIMIT_RESET = 8'd32;

	// Command codes.
	localparam logic [1:0] CMD_ACCUM = 2'd0;
	localparam logic [1:0] CMD_CLASSIFY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Result kinds.
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Configuration register indexes.
	localparam logic REG_START_THR = 1'b0;
	localparam logic REG_ITER_LIMIT = 1'b1;

	// Operations of the shared multiply/divide unit.
	localparam logic OP_DIV = 1'b0;
	localparam logic OP_MUL = 1'b1;

	// Control of the class summing pipeline for one histogram bin.
	typedef struct packed {
		logic clr;
		logic vld;
		logic [PIX_W-1:0] g;
	} sum_ctl_t;

	// Command to the shared multiply/divide unit.
	typedef struct packed {
		logic start;
		logic op;
	} md_cmd_t;

endpackage

`default_nettype wire

// ===== design/isod_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module isod_ram #(
	parameter int unsigned WIDTH = isod_pkg::PIX_W,
	parameter int unsigned DEPTH = isod_pkg::NUM_BINS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/isod_class_sum.sv =====
// Pipelined accumulation of dark and light class counts and weighted sums.
`default_nettype none

module isod_class_sum #(
	parameter int unsigned BIN_W = isod_pkg::BIN_W_DEF,
	parameter int unsigned CNT_W = isod_pkg::CNT_W_DEF,
	parameter int unsigned SUM_W = isod_pkg::SUM_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  isod_pkg::sum_ctl_t           ctl,
	input  logic [BIN_W-1:0]             count,
	input  logic [isod_pkg::PIX_W-1:0]   thr,
	output logic [CNT_W-1:0]             n_dark,
	output logic [SUM_W-1:0]             s_dark,
	output logic [CNT_W-1:0]             n_light,
	output logic [SUM_W-1:0]             s_light,
	output logic                         idle
);

	localparam int unsigned PROD_W = BIN_W + isod_pkg::PIX_W;

	logic              vld_s2;
	logic              dark_s2;
	logic              light_s2;
	logic [BIN_W-1:0]  cnt_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [CNT_W-1:0]  nd_q;
	logic [SUM_W-1:0]  sd_q;
	logic [CNT_W-1:0]  nl_q;
	logic [SUM_W-1:0]  sl_q;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
		end
	end

	// Classify the bin against the threshold and weight its count by its grey level.
	always_ff @(posedge clk) begin
		dark_s2 <= (ctl.g < thr);
		light_s2 <= (ctl.g > thr);
		cnt_s2 <= count;
		prod_s2 <= PROD_W'(count) * PROD_W'(ctl.g);
	end

	// Class accumulators, emptied at the start of every round.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			nd_q <= '0;
			sd_q <= '0;
			nl_q <= '0;
			sl_q <= '0;
		end else if (vld_s2) begin
			if (dark_s2) begin
				nd_q <= nd_q + CNT_W'(cnt_s2);
				sd_q <= sd_q + SUM_W'(prod_s2);
			end
			if (light_s2) begin
				nl_q <= nl_q + CNT_W'(cnt_s2);
				sl_q <= sl_q + SUM_W'(prod_s2);
			end
		end
	end

	assign n_dark = nd_q;
	assign s_dark = sd_q;
	assign n_light = nl_q;
	assign s_light = sl_q;
	assign idle = !vld_s2;

endmodule

`default_nettype wire

// ===== design/isod_muldiv.sv =====
// Shared bit-serial unit: restoring divide and shift-add multiply on one adder.
`default_nettype none

module isod_muldiv #(
	parameter int unsigned CNT_W = isod_pkg::CNT_W_DEF,
	parameter int unsigned SUM_W = isod_pkg::SUM_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isod_pkg::md_cmd_t     cmd,
	input  logic [SUM_W-1:0]      opa,
	input  logic [CNT_W-1:0]      opb,
	output logic                  done,
	output logic [SUM_W-1:0]      quo,
	output logic [CNT_W-1:0]      rem,
	output logic [2*CNT_W-1:0]    prod
);

	localparam int unsigned CW = $clog2(SUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic             op_q;
	logic [CNT_W-1:0] hi_q;
	logic [SUM_W-1:0] lo_q;
	logic [CNT_W-1:0] b_q;
	logic [CNT_W:0]   add_a;
	logic [CNT_W:0]   add_b;
	logic             add_cin;
	logic [CNT_W+1:0] add_sum;
	logic [CNT_W-1:0] hi_d;
	logic [SUM_W-1:0] lo_d;

	// One step: the divide subtracts the divisor from the shifted remainder,
	// the multiply adds the multiplicand when the low multiplier bit is set.
	always_comb begin
		add_a = {1'b0, hi_q};
		add_b = '0;
		add_cin = 1'b0;
		hi_d = hi_q;
		lo_d = '0;
		if (op_q == isod_pkg::OP_DIV) begin
			add_a = {hi_q, lo_q[SUM_W-1]};
			add_b = ~{1'b0, b_q};
			add_cin = 1'b1;
		end else begin
			add_b = lo_q[0] ? {1'b0, b_q} : '0;
		end
		add_sum = {1'b0, add_a} + {1'b0, add_b} + (CNT_W + 2)'(add_cin);
		if (op_q == isod_pkg::OP_DIV) begin
			// Carry out means no borrow: the quotient bit is one.
			hi_d = add_sum[CNT_W+1] ? add_sum[CNT_W-1:0] : add_a[CNT_W-1:0];
			lo_d = {lo_q[SUM_W-2:0], add_sum[CNT_W+1]};
		end else begin
			hi_d = add_sum[CNT_W:1];
			lo_d[CNT_W-1:0] = {add_sum[0], lo_q[CNT_W-1:1]};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && !cmd.start && (cnt_q == CW'(1));
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= (cmd.op == isod_pkg::OP_DIV) ? CW'(SUM_W) : CW'(CNT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Operand and working registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			b_q <= opb;
			hi_q <= '0;
			lo_q <= opa;
		end else if (run_q) begin
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
	end

	assign done = done_q;
	assign quo = lo_q;
	assign rem = hi_q;
	assign prod = {hi_q, lo_q[CNT_W-1:0]};

endmodule

`default_nettype wire

// ===== design/isodata_threshold_binarizer.sv =====
// Top level: histogram, ISODATA threshold search sequencer and pixel binarizer.
// Classify: result strobed the next cycle; busy stays low, one per cycle.
// Accumulate: read-modify-write of the bin RAM; clear: all bin valid bits cleared.
// Search on the last pixel: each round sweeps the 256-bin RAM and then runs
// the bit-serial divide/multiply unit
// (SUM_W = 37, CNT_W = 29 at the default frame size). Results cannot be stalled.
// Reset: thresholds to 50, limit to 32, all bin valid bits cleared at once.
`default_nettype none

module isodata_threshold_binarizer #(
	parameter int unsigned MAX_FRAME_PIXELS = isod_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic [isod_pkg::PIX_W-1:0] pixel,
	input  logic                       last_pixel,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data,
	output logic                       result_strobe,
	output logic                       kind,
	output logic                       binary_value,
	output logic [isod_pkg::PIX_W-1:0] threshold_value,
	output logic                       converged,
	output logic                       empty_class
);

	localparam int unsigned BIN_W = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int unsigned CNT_W = BIN_W + 8;
	localparam int unsigned SUM_W = CNT_W + 8;
	localparam int unsigned PW = isod_pkg::PIX_W;
	localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(MAX_FRAME_PIXELS);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ACC_WR = 4'd1;
	localparam logic [3:0] ST_INIT   = 4'd2;
	localparam logic [3:0] ST_ROUND  = 4'd3;
	localparam logic [3:0] ST_SWEEP  = 4'd4;
	localparam logic [3:0] ST_DRAIN  = 4'd5;
	localparam logic [3:0] ST_CHECK  = 4'd6;
	localparam logic [3:0] ST_DIV_A  = 4'd7;
	localparam logic [3:0] ST_DIV_B  = 4'd8;
	localparam logic [3:0] ST_MUL_A  = 4'd9;
	localparam logic [3:0] ST_MUL_B  = 4'd10;
	localparam logic [3:0] ST_STEP   = 4'd11;
	localparam logic [3:0] ST_FINISH = 4'd12;

	logic [3:0]                  state_q;
	logic [PW-1:0]               start_thr_q;
	logic [7:0]                  iter_lim_q;
	logic [PW-1:0]               cur_thr_q;
	logic [isod_pkg::NUM_BINS-1:0] valid_q;
	logic                        rd_vld_s1;
	logic                        vbit_s1;
	logic [PW-1:0]               g_s1;
	logic                        strobe_q;
	logic                        kind_q;
	logic                        bin_q;
	logic [PW-1:0]               thr_out_q;
	logic                        conv_out_q;
	logic                        empty_out_q;

	logic [PW-1:0]               pix_q;
	logic                        last_q;
	logic [PW-1:0]               sw_q;
	logic [PW-1:0]               t_q;
	logic [PW-1:0]               n_q;
	logic [7:0]                  iter_q;
	logic [PW:0]                 s_q;
	logic [PW-1:0]               qa_q;
	logic [CNT_W-1:0]            ra_q;
	logic [CNT_W-1:0]            rb_q;
	logic [2*CNT_W-1:0]          p1_q;
	logic                        fin_conv_q;
	logic                        fin_empty_q;

	logic                        accept;
	logic [PW-1:0]               rd_addr;
	logic [BIN_W-1:0]            ram_rdata;
	logic [BIN_W-1:0]            bin_cur;
	logic [BIN_W-1:0]            bin_inc;
	isod_pkg::sum_ctl_t          sum_ctl;
	logic [CNT_W-1:0]            n_dark;
	logic [SUM_W-1:0]            s_dark;
	logic [CNT_W-1:0]            n_light;
	logic [SUM_W-1:0]            s_light;
	logic                        sum_idle;
	isod_pkg::md_cmd_t           md_cmd;
	logic [SUM_W-1:0]            md_a;
	logic [CNT_W-1:0]            md_b;
	logic                        md_done;
	logic [SUM_W-1:0]            md_quo;
	logic [CNT_W-1:0]            md_rem;
	logic [2*CNT_W-1:0]          md_prod;
	logic [PW:0]                 s_sum;
	logic                        class_empty;
	logic [7:0]                  lim_eff;
	logic [7:0]                  iter_next;
	logic [PW-1:0]               mean_half;
	logic [PW-1:0]               mean_up;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// Histogram RAM: read at the incoming pixel when idle, else at the sweep address.
	assign rd_addr = (state_q == ST_IDLE) ? pixel : sw_q;
	assign bin_cur = vbit_s1 ? ram_rdata : '0;
	assign bin_inc = (bin_cur < BIN_MAX) ? bin_cur + BIN_W'(1) : bin_cur;

	isod_ram #(
		.WIDTH(BIN_W),
		.DEPTH(isod_pkg::NUM_BINS)
	) u_hist_ram (
		.clk  (clk),
		.we   (state_q == ST_ACC_WR),
		.waddr(pix_q),
		.wdata(bin_inc),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Class sums over one sweep of the histogram.
	assign sum_ctl = '{clr: (state_q == ST_ROUND), vld: rd_vld_s1, g: g_s1};

	isod_class_sum #(
		.BIN_W(BIN_W),
		.CNT_W(CNT_W),
		.SUM_W(SUM_W)
	) u_class_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sum_ctl),
		.count  (bin_cur),
		.thr    (t_q),
		.n_dark (n_dark),
		.s_dark (s_dark),
		.n_light(n_light),
		.s_light(s_light),
		.idle   (sum_idle)
	);

	// Round arithmetic helpers.
	assign class_empty = (n_dark == '0) || (n_light == '0);
	assign s_sum = {1'b0, qa_q} + {1'b0, md_quo[PW-1:0]};
	assign lim_eff = (iter_lim_q == '0) ? 8'd1 : iter_lim_q;
	assign iter_next = iter_q + 8'd1;
	assign mean_half = s_q[PW:1];
	assign mean_up = (&mean_half) ? mean_half : mean_half + PW'(1);

	// Operations issued to the shared unit: two divides for the class means,
	// then, for an odd sum of quotients, two products to settle the rounding.
	always_comb begin
		md_cmd = '0;
		md_a = s_dark;
		md_b = n_dark;
		if (state_q == ST_CHECK && !class_empty) begin
			md_cmd.start = 1'b1;
			md_cmd.op = isod_pkg::OP_DIV;
		end else if (state_q == ST_DIV_A && md_done) begin
			md_cmd.start = 1'b1;
			md_cmd.op = isod_pkg::OP_DIV;
			md_a = s_light;
			md_b = n_light;
		end else if (state_q == ST_DIV_B && md_done && s_sum[0]) begin
			md_cmd.start = 1'b1;
			md_cmd.op = isod_pkg::OP_MUL;
			md_a = SUM_W'(ra_q);
			md_b = n_light;
		end else if (state_q == ST_MUL_A && md_done) begin
			md_cmd.start = 1'b1;
			md_cmd.op = isod_pkg::OP_MUL;
			md_a = SUM_W'(n_light - rb_q);
			md_b = n_dark;
		end
	end

	isod_muldiv #(
		.CNT_W(CNT_W),
		.SUM_W(SUM_W)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (md_cmd),
		.opa   (md_a),
		.opb   (md_b),
		.done  (md_done),
		.quo   (md_quo),
		.rem   (md_rem),
		.prod  (md_prod)
	);

	// Sequencer, configuration, bin valid bits and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_thr_q <= isod_pkg::START_THR_RESET;
			iter_lim_q <= isod_pkg::ITER_LIMIT_RESET;
			cur_thr_q <= isod_pkg::START_THR_RESET;
			valid_q <= '0;
			rd_vld_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (accept && command == isod_pkg::CMD_CLASSIFY) ||
				(state_q == ST_FINISH);
			rd_vld_s1 <= (state_q == ST_SWEEP);
			if (cfg_we) begin
				unique case (cfg_index)
					isod_pkg::REG_START_THR: start_thr_q <= cfg_data;
					isod_pkg::REG_ITER_LIMIT: iter_lim_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (command)
							isod_pkg::CMD_ACCUM: state_q <= ST_ACC_WR;
							isod_pkg::CMD_CLASSIFY: ;
							isod_pkg::CMD_CLEAR: valid_q <= '0;
							default: ;
						endcase
					end
				end
				ST_ACC_WR: begin
					valid_q[pix_q] <= 1'b1;
					state_q <= last_q ? ST_INIT : ST_IDLE;
				end
				ST_INIT: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (&sw_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && sum_idle) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= class_empty ? ST_FINISH : ST_DIV_A;
				ST_DIV_A: begin
					if (md_done) begin
						state_q <= ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (md_done) begin
						state_q <= s_sum[0] ? ST_MUL_A : ST_STEP;
					end
				end
				ST_MUL_A: begin
					if (md_done) begin
						state_q <= ST_MUL_B;
					end
				end
				ST_MUL_B: begin
					if (md_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (n_q == t_q || iter_next == lim_eff) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_FINISH: begin
					cur_thr_q <= t_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the search and the result word.
	always_ff @(posedge clk) begin
		vbit_s1 <= valid_q[rd_addr];
		g_s1 <= sw_q;
		unique case (state_q)
			ST_IDLE: begin
				pix_q <= pixel;
				last_q <= last_pixel;
				kind_q <= isod_pkg::KIND_PIXEL;
				bin_q <= (pixel >= cur_thr_q);
				thr_out_q <= cur_thr_q;
				conv_out_q <= 1'b0;
				empty_out_q <= 1'b0;
			end
			ST_INIT: begin
				t_q <= start_thr_q;
				iter_q <= '0;
			end
			ST_ROUND: sw_q <= '0;
			ST_SWEEP: sw_q <= sw_q + PW'(1);
			ST_CHECK: begin
				fin_empty_q <= class_empty;
				fin_conv_q <= 1'b0;
			end
			ST_DIV_A: begin
				if (md_done) begin
					qa_q <= md_quo[PW-1:0];
					ra_q <= md_rem;
				end
			end
			ST_DIV_B: begin
				if (md_done) begin
					rb_q <= md_rem;
					s_q <= s_sum;
					n_q <= s_sum[PW:1];
				end
			end
			ST_MUL_A: begin
				if (md_done) begin
					p1_q <= md_prod;
				end
			end
			ST_MUL_B: begin
				// Fractional parts of the two means add up to one or more.
				if (md_done) begin
					n_q <= (p1_q >= md_prod) ? mean_up : mean_half;
				end
			end
			ST_STEP: begin
				t_q <= n_q;
				iter_q <= iter_next;
				fin_conv_q <= (n_q == t_q);
			end
			ST_FINISH: begin
				kind_q <= isod_pkg::KIND_REPORT;
				bin_q <= 1'b0;
				thr_out_q <= t_q;
				conv_out_q <= fin_conv_q;
				empty_out_q <= fin_empty_q;
			end
			default: ;
		endcase
	end

	assign result_strobe = strobe_q;
	assign kind = kind_q;
	assign binary_value = bin_q;
	assign threshold_value = thr_out_q;
	assign converged = conv_out_q;
	assign empty_class = empty_out_q;

endmodule

`default_nettype wire

// ===== design/isod_checker.sv =====
// Port-level checks of the binarizer, bound to the top level.
`default_nettype none

module isod_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [1:0]                 command,
	input logic [isod_pkg::PIX_W-1:0] pixel,
	input logic                       last_pixel,
	input logic                       cfg_we,
	input logic                       cfg_index,
	input logic [7:0]                 cfg_data,
	input logic                       result_strobe,
	input logic                       kind,
	input logic                       binary_value,
	input logic [isod_pkg::PIX_W-1:0] threshold_value,
	input logic                       converged,
	input logic                       empty_class
);

	// A classified pixel carries no search flags.
	a_pixel_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == isod_pkg::KIND_PIXEL |-> !converged && !empty_class)
		else $error("classified pixel word carries search flags");

	// A search cannot both converge and hit an empty class.
	a_report_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == isod_pkg::KIND_REPORT |-> !(converged && empty_class))
		else $error("threshold report with both flags set");

	// A classify command answers in the next cycle against the threshold shown.
	a_classify: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == isod_pkg::CMD_CLASSIFY |=>
		result_strobe && kind == isod_pkg::KIND_PIXEL &&
		binary_value == ($past(pixel) >= threshold_value))
		else $error("classify word missing or wrong");

	// An accumulate holds the block for its bin update and gives no word then.
	a_accum_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == isod_pkg::CMD_ACCUM |=> busy && !result_strobe)
		else $error("accumulate did not occupy the block");

	// A threshold report only follows a busy search.
	a_report_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == isod_pkg::KIND_REPORT |-> $past(busy))
		else $error("threshold report without a search");

endmodule

bind isodata_threshold_binarizer isod_checker u_isod_checker (.*);

`default_nettype wire

// ===== tb/sv/isodata_threshold_binarizer_tb.sv =====
// Self-checking testbench of the ISODATA threshold binarizer: directed and random words.
`timescale 1ns / 1ps

module isodata_threshold_binarizer_tb;

	// Command code that the block ignores.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned BIN_SAT = 1048576;
	// Drain bound that covers a search at the largest limit of 255 rounds.
	localparam int DRAIN_LIMIT = 500000;
	localparam int IDLE_SETTLE = 6;
	localparam int TIMEOUT_NS = 500000000;

	typedef struct packed {
		logic       kind;
		logic       binary_value;
		logic [7:0] threshold_value;
		logic       converged;
		logic       empty_class;
	} thr_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] command = isod_pkg::CMD_ACCUM;
	logic [7:0] pixel = 8'd0;
	logic       last_pixel = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = isod_pkg::REG_START_THR;
	logic [7:0] cfg_data = 8'd0;
	logic       result_strobe;
	logic       kind;
	logic       binary_value;
	logic [7:0] threshold_value;
	logic       converged;
	logic       empty_class;

	// Shadow state of the block.
	int unsigned bin_count [isod_pkg::NUM_BINS];
	logic [7:0]  cur_thr = isod_pkg::START_THR_RESET;
	logic [7:0]  cfg_start_thr = isod_pkg::START_THR_RESET;
	logic [7:0]  cfg_iter_limit = isod_pkg::ITER_LIMIT_RESET;
	thr_word_t   expected_results [$];

	int  fail_count = 0;
	int  mismatch_count = 0;
	int  words_sent = 0;
	bit  gaps_on = 1'b0;

	isodata_threshold_binarizer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.pixel           (pixel),
		.last_pixel      (last_pixel),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.result_strobe   (result_strobe),
		.kind            (kind),
		.binary_value    (binary_value),
		.threshold_value (threshold_value),
		.converged       (converged),
		.empty_class     (empty_class)
	);

	always #5 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// One round of the intersection search: returns 0 when a class is empty.
	function automatic bit isodata_round(input int unsigned thr, output int unsigned next_thr);
		longint unsigned nd, sd, nl, sl, c, qa, ra, qb, rb, s, r;
		nd = 0;
		sd = 0;
		nl = 0;
		sl = 0;
		next_thr = thr;
		for (int unsigned g = 0; g < isod_pkg::NUM_BINS; g++) begin
			c = bin_count[g];
			if (g < thr) begin
				nd += c;
				sd += c * g;
			end else if (g > thr) begin
				nl += c;
				sl += c * g;
			end
		end
		if (nd == 0 || nl == 0)
			return 1'b0;
		qa = sd / nd;
		ra = sd % nd;
		qb = sl / nl;
		rb = sl % nl;
		s = qa + qb;
		r = s >> 1;
		// The two fractional parts add up to one or more exactly when this holds.
		if (s[0] && ra * nl >= (nl - rb) * nd)
			r += 1;
		if (r > 255)
			r = 255;
		next_thr = 32'(r);
		return 1'b1;
	endfunction

	// Full search from the start threshold; the result becomes the held threshold.
	function automatic void isodata_search(output logic conv, output logic empty);
		int unsigned thr, next_thr, rounds, lim;
		bit done;
		thr = cfg_start_thr;
		lim = (cfg_iter_limit == 0) ? 1 : cfg_iter_limit;
		conv = 1'b0;
		empty = 1'b0;
		done = 1'b0;
		rounds = 0;
		while (!done && rounds < lim) begin
			if (!isodata_round(thr, next_thr)) begin
				empty = 1'b1;
				done = 1'b1;
			end else if (next_thr == thr) begin
				conv = 1'b1;
				done = 1'b1;
			end else begin
				thr = next_thr;
			end
			rounds++;
		end
		cur_thr = thr[7:0];
	endfunction

	// Updates the shadow state for one accepted word and queues its result.
	function automatic void predict_word(input logic [1:0] cmd, input logic [7:0] pix,
			input logic end_frame);
		thr_word_t w;
		logic conv, empty;
		w = '0;
		case (cmd)
			isod_pkg::CMD_ACCUM: begin
				if (bin_count[pix] < BIN_SAT)
					bin_count[pix]++;
				if (end_frame) begin
					isodata_search(conv, empty);
					w.kind = isod_pkg::KIND_REPORT;
					w.threshold_value = cur_thr;
					w.converged = conv;
					w.empty_class = empty;
					expected_results.push_back(w);
				end
			end
			isod_pkg::CMD_CLASSIFY: begin
				w.kind = isod_pkg::KIND_PIXEL;
				w.binary_value = (pix >= cur_thr);
				w.threshold_value = cur_thr;
				expected_results.push_back(w);
			end
			isod_pkg::CMD_CLEAR: begin
				foreach (bin_count[g])
					bin_count[g] = 0;
			end
			default: begin
			end
		endcase
	endfunction

	// Compares each strobed result with the oldest expected one.
	always @(posedge clk) begin : check_results
		thr_word_t got, want;
		if (arst_n && result_strobe === 1'b1) begin
			got = '{kind, binary_value, threshold_value, converged, empty_class};
			if (expected_results.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result kind=%0b bin=%0b thr=%0d conv=%0b empty=%0b",
						$time, got.kind, got.binary_value, got.threshold_value,
						got.converged, got.empty_class);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: mismatch kind %0b/%0b bin %0b/%0b thr %0d/%0d ",
							"conv %0b/%0b empty %0b/%0b (expected/actual)"}, $time,
							want.kind, got.kind, want.binary_value, got.binary_value,
							want.threshold_value, got.threshold_value,
							want.converged, got.converged, want.empty_class, got.empty_class);
				end
			end
		end
	end

	// Offers one word, with a random gap before it, and waits until it is taken.
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] pix, input logic end_frame);
		if (gaps_on && $urandom_range(99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		pixel <= pix;
		last_pixel <= end_frame;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_word(cmd, pix, end_frame);
		if (cmd != CMD_UNUSED)
			words_sent++;
	endtask

	// Stops sending and waits until every expected result has come and the block is idle.
	task automatic wait_idle;
		int n;
		start <= 1'b0;
		n = 0;
		@(posedge clk);
		while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			expected_results.delete();
		end
		// Accumulate and clear words give no result but may still be in flight.
		repeat (IDLE_SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Writes both registers; the block must be idle.
	task automatic set_config(input logic [7:0] thr0, input logic [7:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= isod_pkg::REG_START_THR;
		cfg_data <= thr0;
		@(posedge clk);
		cfg_index <= isod_pkg::REG_ITER_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_start_thr = thr0;
		cfg_iter_limit = lim;
	endtask

	// Classify right after reset, against the reset threshold.
	task automatic test_classify_after_reset;
		send_word(isod_pkg::CMD_CLASSIFY, 8'd0, 1'b0);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd49, 1'b0);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd50, 1'b1);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd255, 1'b0);
	endtask

	// A frame with no dark pixels, then an ignored code and a clear marked last.
	task automatic test_empty_class;
		send_word(isod_pkg::CMD_ACCUM, 8'd255, 1'b1);
		send_word(CMD_UNUSED, 8'd255, 1'b1);
		send_word(isod_pkg::CMD_CLEAR, 8'd0, 1'b1);
	endtask

	// Two well separated modes: the search converges in two rounds.
	task automatic test_convergence;
		send_word(isod_pkg::CMD_ACCUM, 8'd10, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd10, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd200, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd200, 1'b1);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd104, 1'b0);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd105, 1'b0);
	endtask

	// Class means of 1.5 and 4.5: the halves only round up by the exact fraction test.
	task automatic test_rounding;
		wait_idle();
		set_config(8'd3, 8'd32);
		send_word(isod_pkg::CMD_CLEAR, 8'd0, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd1, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd2, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd4, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd5, 1'b1);
	endtask

	// A zero limit runs one round; a start at the top leaves the light class empty.
	task automatic test_iteration_limit;
		wait_idle();
		set_config(8'd128, 8'd0);
		send_word(isod_pkg::CMD_CLEAR, 8'd0, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd10, 1'b0);
		send_word(isod_pkg::CMD_ACCUM, 8'd200, 1'b1);
		wait_idle();
		set_config(8'd255, 8'd1);
		send_word(isod_pkg::CMD_ACCUM, 8'd0, 1'b1);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd254, 1'b0);
		send_word(isod_pkg::CMD_CLASSIFY, 8'd255, 1'b0);
	endtask

	// One frame of clustered or uniform pixels with classify words and noise mixed in.
	task automatic random_frame;
		int n, c0, c1, spread, p;
		bit uniform;
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
		c0 = $urandom_range(255);
		c1 = $urandom_range(255);
		spread = $urandom_range(0, 30);
		uniform = ($urandom_range(3) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8)
				send_word(isod_pkg::CMD_CLASSIFY, 8'($urandom_range(255)),
					1'($urandom_range(1)));
			if ($urandom_range(99) < 3)
				send_word(CMD_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
			if (uniform) begin
				p = $urandom_range(255);
			end else begin
				p = ($urandom_range(1) ? c0 : c1) - spread + int'($urandom_range(0, 2 * spread));
				if (p < 0)
					p = 0;
				if (p > 255)
					p = 255;
			end
			send_word(isod_pkg::CMD_ACCUM, p[7:0], i == n - 1);
		end
		repeat ($urandom_range(0, 3))
			send_word(isod_pkg::CMD_CLASSIFY, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// Random frames under one register setting; histograms sometimes carry over.
	task automatic test_random_frames(input logic [7:0] thr0, input logic [7:0] lim,
			input int n_words);
		int target;
		wait_idle();
		set_config(thr0, lim);
		target = words_sent + n_words;
		while (words_sent < target) begin
			if ($urandom_range(99) < 15)
				send_word(isod_pkg::CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			random_frame();
		end
	endtask

	initial begin
		foreach (bin_count[g])
			bin_count[g] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words and the first random setting run without gaps.
		gaps_on = 1'b0;
		test_classify_after_reset();
		test_empty_class();
		test_convergence();
		test_rounding();
		test_iteration_limit();
		test_random_frames(isod_pkg::START_THR_RESET, isod_pkg::ITER_LIMIT_RESET, 150);

		gaps_on = 1'b1;
		test_random_frames(8'($urandom_range(255)), 8'($urandom_range(1, 16)), 150);
		test_random_frames(8'd0, 8'd1, 60);
		test_random_frames(8'd255, 8'd255, 30);
		test_random_frames(8'($urandom_range(255)), 8'($urandom_range(2, 40)), 110);

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
